// File: hdl/swfd_pkg.sv
// ----------------------------------------------------------------------------
// swfd_pkg
// Shared constants and types of the sync-word frame deframer.
// ----------------------------------------------------------------------------
package swfd_pkg;

  localparam int MAX_WORDS = 32;
  localparam int IDX_W     = $clog2(MAX_WORDS);
  localparam int CNT_W     = $clog2(MAX_WORDS + 1);
  localparam int ADDR_W    = IDX_W + 1;   // bank bit on top of the word index
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [7:0] SEP_BYTE = 8'h7F;

  // frame store write request, front to back
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       data;
  } wr_req_t;

  // one validated frame waiting to be emitted
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] count;
  } frame_cmd_t;

  // back reports a bank free again
  typedef struct packed {
    logic done;
    logic bank;
  } bank_rel_t;

  typedef struct packed {
    logic [1:0] busy;
    logic       wbank;
  } fe_status_t;

endpackage

// File: hdl/swfd_if.sv
// ----------------------------------------------------------------------------
// swfd_in_if / swfd_out_if
// Valid/ready channels of the deframer: received bytes in, decoded words out.
// ----------------------------------------------------------------------------
interface swfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface swfd_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         word_index;
  logic signed [15:0] decoded_value;
  logic [5:0]         coarse_part;
  logic [7:0]         fine_part;
  logic               last;

  modport source (output valid, output word_index, output decoded_value,
                  output coarse_part, output fine_part, output last, input ready);
  modport sink   (input valid, input word_index, input decoded_value,
                  input coarse_part, input fine_part, input last, output ready);
endinterface

// File: hdl/swfd_front.sv
// ----------------------------------------------------------------------------
// swfd_front
// Byte parser: hunts for sync, learns the frame length, writes frame words
// into the current bank and queues a frame once its closing pair checks out.
// ----------------------------------------------------------------------------
module swfd_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_byte,
  output swfd_pkg::wr_req_t       wr,
  output logic                    push,
  output swfd_pkg::frame_cmd_t    push_cmd,
  input  swfd_pkg::bank_rel_t     rel,
  output swfd_pkg::fe_status_t    status
);

  typedef enum logic [5:0] {
    M_HUNT   = 6'b000001,
    M_SEP    = 6'b000010,
    M_SKIP   = 6'b000100,
    M_ALIGN  = 6'b001000,
    M_LEARN  = 6'b010000,
    M_SYNCED = 6'b100000
  } mode_t;

  mode_t                       mode_r, mode_nxt;
  logic                        pp_r, pp_nxt;
  logic [7:0]                  held_r, held_nxt;
  logic [swfd_pkg::CNT_W-1:0]  wc_r, wc_nxt;
  logic [swfd_pkg::CNT_W-1:0]  lw_r, lw_nxt;
  logic                        wb_r, wb_nxt;
  logic [1:0]                  busy_r, busy_nxt;
  logic                        fire;
  logic                        sep_pair;

  // once synced, every byte waits while the write bank is still being emitted
  assign in_ready = !((mode_r == M_SYNCED) && busy_r[wb_r]);
  assign fire     = in_valid && in_ready;
  assign sep_pair = (held_r == swfd_pkg::SEP_BYTE) && (in_byte == swfd_pkg::SEP_BYTE);

  assign status.busy  = busy_r;
  assign status.wbank = wb_r;

  always_comb begin
    mode_nxt = mode_r;
    pp_nxt   = pp_r;
    held_nxt = held_r;
    wc_nxt   = wc_r;
    lw_nxt   = lw_r;
    wb_nxt   = wb_r;
    busy_nxt = busy_r;
    wr.en    = 1'b0;
    wr.addr  = {wb_r, wc_r[swfd_pkg::IDX_W-1:0]};
    wr.data  = {in_byte, held_r};
    push     = 1'b0;
    push_cmd.bank  = wb_r;
    push_cmd.count = lw_r;

    if (rel.done) begin
      busy_nxt[rel.bank] = 1'b0;
    end

    if (fire) begin
      unique case (mode_r)
        M_HUNT: begin
          pp_nxt   = 1'b0;
          held_nxt = '0;
          wc_nxt   = '0;
          lw_nxt   = '0;
          if (in_byte == swfd_pkg::SEP_BYTE) mode_nxt = M_SEP;
        end
        M_SEP: begin
          pp_nxt   = 1'b0;
          mode_nxt = (in_byte == swfd_pkg::SEP_BYTE) ? M_LEARN : M_SKIP;
        end
        M_SKIP: begin
          pp_nxt   = 1'b0;
          mode_nxt = M_ALIGN;
        end
        M_ALIGN, M_LEARN, M_SYNCED: begin
          if (!pp_r) begin
            held_nxt = in_byte;
            pp_nxt   = 1'b1;
          end else begin
            pp_nxt = 1'b0;
            if (mode_r == M_ALIGN) begin
              if (sep_pair) mode_nxt = M_LEARN;
            end else if (mode_r == M_LEARN) begin
              if (sep_pair) begin
                mode_nxt = M_SYNCED;
                wc_nxt   = '0;
              end else if (lw_r >= swfd_pkg::CNT_W'(swfd_pkg::MAX_WORDS)) begin
                mode_nxt = M_HUNT;
                held_nxt = '0;
                wc_nxt   = '0;
                lw_nxt   = '0;
              end else begin
                lw_nxt = lw_r + 1'b1;
              end
            end else begin
              if (wc_r < lw_r) begin
                wr.en  = 1'b1;
                wc_nxt = wc_r + 1'b1;
              end else if (sep_pair) begin
                wc_nxt = '0;
                // an empty frame emits nothing and keeps its bank
                if (lw_r != '0) begin
                  push             = 1'b1;
                  busy_nxt[wb_r]   = 1'b1;
                  wb_nxt           = !wb_r;
                end
              end else begin
                mode_nxt = M_HUNT;
                held_nxt = '0;
                wc_nxt   = '0;
                lw_nxt   = '0;
              end
            end
          end
        end
        default: begin
          mode_nxt = M_HUNT;
          pp_nxt   = 1'b0;
          held_nxt = '0;
          wc_nxt   = '0;
          lw_nxt   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_HUNT;
      pp_r   <= 1'b0;
      held_r <= '0;
      wc_r   <= '0;
      lw_r   <= '0;
      wb_r   <= 1'b0;
      busy_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      pp_r   <= pp_nxt;
      held_r <= held_nxt;
      wc_r   <= wc_nxt;
      lw_r   <= lw_nxt;
      wb_r   <= wb_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

// File: hdl/swfd_queue.sv
// ----------------------------------------------------------------------------
// swfd_queue
// Small FIFO of validated frames between the parser and the emitter.
// ----------------------------------------------------------------------------
module swfd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  swfd_pkg::frame_cmd_t push_cmd,
  input  logic                 pop,
  output logic                 q_valid,
  output swfd_pkg::frame_cmd_t q_cmd,
  output logic                 q_full
);

  swfd_pkg::frame_cmd_t             ent_r [swfd_pkg::QDEPTH];
  logic [swfd_pkg::QPTR_W-1:0]      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [swfd_pkg::QPTR_W:0]        cnt_r, cnt_nxt;

  assign q_valid = (cnt_r != '0);
  assign q_full  = (cnt_r == (swfd_pkg::QPTR_W+1)'(swfd_pkg::QDEPTH));
  assign q_cmd   = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (swfd_pkg::QPTR_W+1)'(push) - (swfd_pkg::QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hdl/swfd_back.sv
// ----------------------------------------------------------------------------
// swfd_back
// Two-bank frame store and word emitter: reads a queued frame word by word,
// decodes each word into the output register.
// ----------------------------------------------------------------------------
module swfd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  swfd_pkg::wr_req_t     wr,
  input  logic                  q_valid,
  input  swfd_pkg::frame_cmd_t  q_cmd,
  output logic                  pop,
  output swfd_pkg::bank_rel_t   rel,
  swfd_out_if.source            out_ch
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_READ = 3'b010,
    B_LOAD = 3'b100
  } bstate_t;

  logic [15:0]                 mem [2*swfd_pkg::MAX_WORDS];
  logic [15:0]                 rd_data_r;
  bstate_t                     st_r, st_nxt;
  logic                        bank_r, bank_nxt;
  logic [swfd_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [swfd_pkg::IDX_W-1:0]  k_r, k_nxt;
  logic                        ov_r, ov_nxt;
  logic                        load;
  logic                        is_last;
  logic [4:0]                  oidx_r;
  logic [15:0]                 oval_r;
  logic [5:0]                  ocoarse_r;
  logic [7:0]                  ofine_r;
  logic                        olast_r;

  assign is_last = ((swfd_pkg::CNT_W'(k_r) + 1'b1) == cnt_r);
  assign load    = (st_r == B_LOAD) && (!ov_r || out_ch.ready);
  assign pop     = (st_r == B_IDLE) && q_valid;

  // bank is free once its final word sits in the output register
  assign rel.done = load && is_last;
  assign rel.bank = bank_r;

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
    rd_data_r <= mem[{bank_r, k_r}];
  end

  always_comb begin
    st_nxt   = st_r;
    bank_nxt = bank_r;
    cnt_nxt  = cnt_r;
    k_nxt    = k_r;
    ov_nxt   = ov_r;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    unique case (st_r)
      B_IDLE: begin
        if (q_valid) begin
          bank_nxt = q_cmd.bank;
          cnt_nxt  = q_cmd.count;
          k_nxt    = '0;
          st_nxt   = B_READ;
        end
      end
      B_READ: st_nxt = B_LOAD;
      B_LOAD: begin
        if (load) begin
          ov_nxt = 1'b1;
          if (is_last) begin
            st_nxt = B_IDLE;
          end else begin
            k_nxt  = k_r + 1'b1;
            st_nxt = B_READ;
          end
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
    bank_r <= bank_nxt;
    cnt_r  <= cnt_nxt;
    k_r    <= k_nxt;
    if (load) begin
      oidx_r    <= 5'(k_r);
      oval_r    <= {rd_data_r[15:8], ~rd_data_r[7:0]};
      ocoarse_r <= rd_data_r[15:10];
      ofine_r   <= rd_data_r[7:0];
      olast_r   <= is_last;
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.word_index    = oidx_r;
  assign out_ch.decoded_value = oval_r;
  assign out_ch.coarse_part   = ocoarse_r;
  assign out_ch.fine_part     = ofine_r;
  assign out_ch.last          = olast_r;

endmodule

// File: hdl/sync_word_frame_deframer.sv
// ----------------------------------------------------------------------------
// sync_word_frame_deframer
// Emission: once a frame's closing byte transfers, it is queued; the idle
//   emitter takes it and, for each word in turn, reads the store (B_READ) and
//   loads the output register (B_LOAD), waiting there while the output is
//   stalled. Throughput: one byte per cycle; once synced, every byte stalls
//   while the write bank is still being emitted. Reset (synchronous, rst_n
//   low) returns to sync hunt.
// ----------------------------------------------------------------------------
module sync_word_frame_deframer (
  input  logic       clk,
  input  logic       rst_n,
  swfd_in_if.sink    in_ch,
  swfd_out_if.source out_ch
);

  swfd_pkg::wr_req_t    wr;
  logic                 push;
  swfd_pkg::frame_cmd_t push_cmd;
  swfd_pkg::bank_rel_t  rel;
  swfd_pkg::fe_status_t status;
  logic                 pop;
  logic                 q_valid;
  logic                 q_full;
  swfd_pkg::frame_cmd_t q_cmd;

  swfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.rx_byte),
    .wr       (wr),
    .push     (push),
    .push_cmd (push_cmd),
    .rel      (rel),
    .status   (status)
  );

  swfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_full   (q_full)
  );

  swfd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (pop),
    .rel     (rel),
    .out_ch  (out_ch)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full) else $error("frame queue overflow");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> !status.busy[wr.addr[swfd_pkg::ADDR_W-1]])
    else $error("store into a bank still being emitted");

  a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rel.done |-> status.busy[rel.bank]) else $error("release of an idle bank");

endmodule

// File: bench/sync_word_frame_deframer_tb.sv
// ----------------------------------------------------------------------------
// sync_word_frame_deframer_tb
// Feeds byte streams into the deframer: separator hunts, both realignment
// paths, length learning, frames of up to six words and of the limit,
// over-long learning, empty frames, bad closing pairs and noise. A behavioral
// tracker predicts every decoded word, and each word out is checked in order.
// ----------------------------------------------------------------------------
module sync_word_frame_deframer_tb;

  localparam int LIMIT_CYCLES = 200000;
  localparam int STALL_CYCLES = 400;
  localparam int SETTLE_CYCLES = 24;
  localparam int STREAM_BYTES = 320;

  localparam logic [7:0] SEP = swfd_pkg::SEP_BYTE;

  // short opening stream: empty frame, then the skip path with extreme bytes
  localparam logic [7:0] OPENING [25] = '{
    SEP, SEP, SEP, SEP, SEP, SEP, 8'h01, 8'h02,
    SEP, 8'h55, 8'hAA, SEP, SEP, 8'h12, 8'h34, SEP, SEP,
    8'h00, 8'hFF, SEP, SEP, 8'hFF, 8'h00, SEP, 8'h00
  };

  typedef enum logic [2:0] {
    HUNT_SEP, SEP_OR_FIRST, SKIP_ONE, ALIGN_PAIRS, LEARN_LEN, SYNCED
  } sync_mode_e;

  typedef struct packed {
    logic [4:0]         word_index;
    logic signed [15:0] decoded_value;
    logic [5:0]         coarse_part;
    logic [7:0]         fine_part;
    logic               last;
  } deframed_word_t;

  logic clk;
  logic rst_n;

  swfd_in_if  in_if ();
  swfd_out_if out_if ();

  sync_word_frame_deframer u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // tracker state
  sync_mode_e  mode;
  logic        pair_odd;
  logic [7:0]  held_byte;
  int          stored_words;
  int          learned_words;
  logic [15:0] frame_words [swfd_pkg::MAX_WORDS];

  logic [7:0]     bytes_to_send [$];
  deframed_word_t words_due [$];
  int             total_bytes;
  int             accepted;
  int             mismatches;
  int             hold_left;
  logic           hold_used;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic clear_sync();
    mode          = HUNT_SEP;
    pair_odd      = 1'b0;
    held_byte     = 8'h00;
    stored_words  = 0;
    learned_words = 0;
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0]     first;
    logic           sep_pair;
    deframed_word_t w;
    int             k;
    case (mode)
      HUNT_SEP: begin
        clear_sync();
        if (b == SEP) mode = SEP_OR_FIRST;
      end
      SEP_OR_FIRST: begin
        pair_odd = 1'b0;
        mode = (b == SEP) ? LEARN_LEN : SKIP_ONE;
      end
      SKIP_ONE: begin
        pair_odd = 1'b0;
        mode = ALIGN_PAIRS;
      end
      default: begin
        if (!pair_odd) begin
          held_byte = b;
          pair_odd  = 1'b1;
        end else begin
          pair_odd = 1'b0;
          first    = held_byte;
          sep_pair = (first == SEP) && (b == SEP);
          if (mode == ALIGN_PAIRS) begin
            if (sep_pair) mode = LEARN_LEN;
          end else if (mode == LEARN_LEN) begin
            if (sep_pair) begin
              mode = SYNCED;
              stored_words = 0;
            end else if (learned_words >= swfd_pkg::MAX_WORDS) begin
              clear_sync();
            end else begin
              learned_words++;
            end
          end else if (stored_words < learned_words) begin
            frame_words[stored_words] = {b, first};
            stored_words++;
          end else if (sep_pair) begin
            stored_words = 0;
            for (k = 0; k < learned_words; k++) begin
              w.word_index    = k[4:0];
              w.decoded_value = {frame_words[k][15:8], ~frame_words[k][7:0]};
              w.coarse_part   = frame_words[k][15:10];
              w.fine_part     = frame_words[k][7:0];
              w.last          = (k == learned_words - 1);
              words_due.push_back(w);
            end
          end else begin
            clear_sync();
          end
        end
      end
    endcase
  endtask

  // separator shows up often so that near-miss pairs occur
  function automatic logic [7:0] any_byte();
    return ($urandom_range(0, 7) == 0) ? SEP : 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] non_sep_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 254));
    if (b >= SEP) b = b + 8'd1;
    return b;
  endfunction

  task automatic push_sep_pair();
    bytes_to_send.push_back(SEP);
    bytes_to_send.push_back(SEP);
  endtask

  task automatic push_any_pair();
    bytes_to_send.push_back(any_byte());
    bytes_to_send.push_back(any_byte());
  endtask

  task automatic push_pair_not_sep();
    logic [7:0] first;
    first = any_byte();
    bytes_to_send.push_back(first);
    bytes_to_send.push_back((first == SEP) ? non_sep_byte() : any_byte());
  endtask

  // hunt, realign (direct or via skip), learn n_words, n_frames good frames,
  // then one frame with a broken closing pair to fall back to hunting
  task automatic add_frame_run(input int n_words, input int n_frames);
    repeat ($urandom_range(0, 3)) bytes_to_send.push_back(non_sep_byte());
    bytes_to_send.push_back(SEP);
    if ($urandom_range(0, 1) == 1) begin
      bytes_to_send.push_back(non_sep_byte());
      bytes_to_send.push_back(any_byte());
      repeat ($urandom_range(0, 2)) push_pair_not_sep();
      push_sep_pair();
    end else begin
      bytes_to_send.push_back(SEP);
    end
    repeat (n_words) push_pair_not_sep();
    push_sep_pair();
    repeat (n_frames) begin
      repeat (n_words) push_any_pair();
      push_sep_pair();
    end
    repeat (n_words) push_any_pair();
    push_pair_not_sep();
  endtask

  task automatic add_over_limit();
    push_sep_pair();
    repeat (swfd_pkg::MAX_WORDS + 1) push_pair_not_sep();
  endtask

  function automatic int idle_phase();
    if (accepted * 3 < total_bytes) return 0;
    if (accepted * 3 < total_bytes * 2) return 1;
    return 2;
  endfunction

  task automatic check_field(input string field, input int expd, input int got);
    if (expd != got) begin
      $display("%0t  %s: expected %0d, actual %0d", $time, field, expd, got);
      mismatches++;
    end
  endtask

  // byte sender; tracker advances on every transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid   <= 1'b0;
      in_if.rx_byte <= 8'h00;
      accepted      <= 0;
      clear_sync();
    end else begin
      if (in_if.valid && in_if.ready) begin
        deframe_byte(in_if.rx_byte);
        accepted <= accepted + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (bytes_to_send.size() > 0 &&
            $urandom_range(0, 99) >= (idle_phase() == 0 ? 27 :
                                      idle_phase() == 1 ? 56 : 0)) begin
          in_if.valid   <= 1'b1;
          in_if.rx_byte <= bytes_to_send.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // one long output hold-off while words are pending, so both banks fill up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (!hold_used && accepted * 3 >= total_bytes && words_due.size() > 0) begin
      hold_left <= STALL_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // word receiver and checker
  always @(posedge clk) begin
    deframed_word_t w;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (words_due.size() == 0) begin
          $display("%0t  unexpected word: index %0d value %0d", $time,
                   out_if.word_index, out_if.decoded_value);
          mismatches++;
        end else begin
          w = words_due.pop_front();
          check_field("word_index", w.word_index, out_if.word_index);
          check_field("decoded_value", w.decoded_value, out_if.decoded_value);
          check_field("coarse_part", w.coarse_part, out_if.coarse_part);
          check_field("fine_part", w.fine_part, out_if.fine_part);
          check_field("last", w.last, out_if.last);
        end
      end
      out_if.ready <= (hold_left == 0) &&
                      ($urandom_range(0, 99) >= (idle_phase() == 0 ? 56 :
                                                 idle_phase() == 1 ? 27 : 0));
    end
  end

  initial begin
    int r;
    rst_n       = 1'b0;
    total_bytes = 1;

    // fixed corner runs first: longest frame, then over-long learning
    foreach (OPENING[i]) bytes_to_send.push_back(OPENING[i]);
    add_frame_run(swfd_pkg::MAX_WORDS, 1);
    add_over_limit();
    while (bytes_to_send.size() < STREAM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        repeat ($urandom_range(1, 8)) bytes_to_send.push_back(any_byte());
      end else begin
        add_frame_run($urandom_range(0, 6), $urandom_range(1, 3));
      end
    end
    total_bytes = bytes_to_send.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_to_send.size() != 0 || in_if.valid) @(posedge clk);
    while (words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && words_due.size() == 0) begin
      $display("** sync_word_frame_deframer: PASSED **");
    end else begin
      $display("** sync_word_frame_deframer: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("** sync_word_frame_deframer: FAILED **");
    $finish;
  end

endmodule
